// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with reset masking.
`define FIJB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Same-cycle implication.
`define FIJB_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
    `FIJB_ASSERT(lbl, clk, rstn, (pre) |-> (post), msg)

`endif

// ----- design/fijb_pkg.sv -----
// Package: widths, codes and shared types of the frame input jitter buffer.
`timescale 1ns / 1ps
`default_nettype none

package fijb_pkg;

    localparam int FRAME_W       = 32;
    localparam int PAYLOAD_W     = 16;
    localparam int LD_W          = 4;
    localparam int LD_MAX        = 2 ** LD_W - 1;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;
    localparam int MAX_RESULTS   = 16;
    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 16;
    localparam int IN_DATA_W     = 48;
    localparam int IN_USER_W     = 4;
    localparam int OUT_DATA_W    = 64;
    localparam int OUT_USER_W    = 4;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 3'd0,
        OP_INIT    = 3'd1,
        OP_LOCAL   = 3'd2,
        OP_REMOTE  = 3'd3,
        OP_ADVANCE = 3'd4,
        OP_WALK    = 3'd5,
        OP_QUERY   = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE   = 2'd0,
        STS_REJECT = 2'd1,
        STS_SKIP   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC,
        ST_HI,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic l_we;
        logic r_we;
        logic rd_en;
    } store_ctl_t;

endpackage

`default_nettype wire

// ----- design/fijb_store.sv -----
// Local and remote word memories, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module fijb_store #(
    parameter int DEPTH = fijb_pkg::DEPTH_DEF,
    parameter int WIDTH = fijb_pkg::PAYLOAD_W
) (
    input  logic                     aclk,
    input  fijb_pkg::store_ctl_t     ctl,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         l_rdata,
    output logic [WIDTH-1:0]         r_rdata
);
    import fijb_pkg::*;

    logic [WIDTH-1:0] l_mem [DEPTH];
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] l_rdata_reg;
    logic [WIDTH-1:0] r_rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.l_we) begin
            l_mem[waddr] <= wdata;
        end
        if (ctl.r_we) begin
            r_mem[waddr] <= wdata;
        end
        if (ctl.rd_en) begin
            l_rdata_reg <= l_mem[raddr];
            r_rdata_reg <= r_mem[raddr];
        end
    end

    assign l_rdata = l_rdata_reg;
    assign r_rdata = r_rdata_reg;

endmodule

`default_nettype wire

// ----- design/frame_input_jitter_buffer.sv -----
// Frame input jitter buffer: circular slot store indexed by frame number.
// A word passes ST_CMP, ST_EXEC, then ST_HI or ST_READ, and ST_EMIT loads the output
// register when it is free. A walk repeats ST_READ and ST_EMIT for each emitted frame,
// as the read of the word memory is registered. s_axis_tready drops until the
// last result of a word is loaded. Reset (sync, active low) clears frame counters,
// slot flags and local_delay; word memories are masked by the flags.
`timescale 1ns / 1ps
`default_nettype none

module frame_input_jitter_buffer #(
    parameter int DEPTH     = fijb_pkg::DEPTH_DEF,
    parameter int WORD_BITS = fijb_pkg::WORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fijb_pkg::LD_W-1:0]         cfg_wr_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] frame_number, [47:32] payload
    input  logic [fijb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [2:0] operation, [3] from_batch
    input  logic [fijb_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] result_frame, [47:32] local_word, [63:48] remote_word
    output logic [fijb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [1:0] status, [2] has_data, [3] ready_to_advance
    output logic [fijb_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    output logic                              m_axis_tlast
);
    import fijb_pkg::*;

    localparam int SB       = $clog2(DEPTH);
    localparam int SW       = (WORD_BITS < PAYLOAD_W) ? WORD_BITS : PAYLOAD_W;
    localparam int WALK_MAX = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
    localparam int CB       = $clog2(WALK_MAX);

    typedef logic [SB-1:0] slot_t;
    typedef logic [SB:0]   psum_t;
    typedef logic [SW-1:0] word_t;

    function automatic slot_t slot_inc(input slot_t s);
        return (s == slot_t'(DEPTH - 1)) ? '0 : slot_t'(s + 1'b1);
    endfunction

    function automatic slot_t slot_add(input slot_t base, input psum_t off);
        psum_t t;
        t = psum_t'(base) + off;
        if (t >= psum_t'(DEPTH)) begin
            t = t - psum_t'(DEPTH);
        end
        return slot_t'(t);
    endfunction

    state_t                state_reg, state_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [FRAME_W-1:0]    frame_reg, frame_next;
    word_t                 payload_reg, payload_next;
    logic                  batch_reg, batch_next;
    logic [LD_W-1:0]       delay_reg, delay_next;
    logic [FRAME_W-1:0]    cur_reg, cur_next;
    slot_t                 cs_reg, cs_next;
    logic [FRAME_W-1:0]    maxr_reg, maxr_next;
    logic [FRAME_W-1:0]    maxl_reg, maxl_next;
    logic [FRAME_W-1:0]    hi_reg, hi_next;
    logic [DEPTH-1:0]      lf_reg, lf_next;
    logic [DEPTH-1:0]      rf_reg, rf_next;
    logic [DEPTH-1:0]      lwv_reg, lwv_next;
    logic [FRAME_W:0]      diff_reg, diff_next;
    logic [FRAME_W:0]      sum_reg, sum_next;
    logic                  f_le_hi_reg, f_le_hi_next;
    logic                  cur_le_hi_reg, cur_le_hi_next;
    status_t               pst_reg, pst_next;
    logic [FRAME_W-1:0]    pfr_reg, pfr_next;
    logic                  phas_reg, phas_next;
    logic                  prw_reg, prw_next;
    logic                  plast_reg, plast_next;
    logic [FRAME_W-1:0]    wf_reg, wf_next;
    slot_t                 ws_reg, ws_next;
    logic [CB-1:0]         cnt_reg, cnt_next;
    logic                  rlv_reg, rlv_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [OUT_USER_W-1:0] m_user_reg, m_user_next;
    logic                  m_last_reg, m_last_next;

    store_ctl_t st_ctl;
    slot_t      st_waddr;
    slot_t      st_raddr;
    word_t      l_rdata;
    word_t      r_rdata;

    logic  out_free;
    logic  rdy;
    logic  adv_ok;
    logic  walk_more;
    slot_t ins_slot;

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign rdy       = (cur_reg <= hi_reg) && lf_reg[cs_reg] && rf_reg[cs_reg];
    assign adv_ok    = cur_le_hi_reg && lf_reg[cs_reg] && rf_reg[cs_reg];
    assign walk_more = (cnt_reg < CB'(WALK_MAX - 1)) && (wf_reg < hi_reg)
                       && lf_reg[slot_inc(ws_reg)];
    assign ins_slot  = (op_reg == OP_LOCAL) ? slot_add(cs_reg, psum_t'(delay_reg))
                                            : slot_add(cs_reg, diff_reg[SB:0]);

    fijb_store #(
        .DEPTH (DEPTH),
        .WIDTH (SW)
    ) u_store (
        .aclk    (aclk),
        .ctl     (st_ctl),
        .waddr   (st_waddr),
        .raddr   (st_raddr),
        .wdata   (payload_reg),
        .l_rdata (l_rdata),
        .r_rdata (r_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = ST_EXEC;
            ST_EXEC: begin
                if (op_reg == OP_WALK && lf_reg[cs_reg]) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_HI;
                end
            end
            ST_HI:   state_next = ST_EMIT;
            ST_READ: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = plast_reg ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        slot_t js;
        js             = '0;
        op_next        = op_reg;
        frame_next     = frame_reg;
        payload_next   = payload_reg;
        batch_next     = batch_reg;
        delay_next     = cfg_wr_en ? cfg_wr_data : delay_reg;
        cur_next       = cur_reg;
        cs_next        = cs_reg;
        maxr_next      = maxr_reg;
        maxl_next      = maxl_reg;
        hi_next        = hi_reg;
        lf_next        = lf_reg;
        rf_next        = rf_reg;
        lwv_next       = lwv_reg;
        diff_next      = diff_reg;
        sum_next       = sum_reg;
        f_le_hi_next   = f_le_hi_reg;
        cur_le_hi_next = cur_le_hi_reg;
        pst_next       = pst_reg;
        pfr_next       = pfr_reg;
        phas_next      = phas_reg;
        prw_next       = prw_reg;
        plast_next     = plast_reg;
        wf_next        = wf_reg;
        ws_next        = ws_reg;
        cnt_next       = cnt_reg;
        rlv_next       = rlv_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_last_next    = m_last_reg;
        st_ctl         = '0;
        st_waddr       = ins_slot;
        st_raddr       = cs_reg;
        s_axis_tready  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    op_next      = s_axis_tuser[OP_W-1:0];
                    batch_next   = s_axis_tuser[OP_W];
                    frame_next   = s_axis_tdata[FRAME_W-1:0];
                    payload_next = word_t'(s_axis_tdata[FRAME_W +: PAYLOAD_W]);
                end
            end
            ST_CMP: begin
                diff_next      = {1'b0, frame_reg} - {1'b0, cur_reg};
                sum_next       = {1'b0, cur_reg} + (FRAME_W + 1)'(delay_reg);
                f_le_hi_next   = frame_reg <= hi_reg;
                cur_le_hi_next = cur_reg <= hi_reg;
            end
            ST_EXEC: begin
                pst_next   = STS_DONE;
                pfr_next   = cur_reg;
                phas_next  = 1'b0;
                prw_next   = 1'b0;
                plast_next = 1'b1;
                case (op_reg)
                    OP_CLEAR: begin
                        lf_next   = '0;
                        rf_next   = '0;
                        lwv_next  = '0;
                        cur_next  = '0;
                        cs_next   = '0;
                        maxr_next = '0;
                        pfr_next  = '0;
                    end
                    OP_INIT: begin
                        for (int i = 0; i < LD_MAX; i++) begin
                            if (LD_W'(i) < delay_reg) begin
                                lf_next[js] = 1'b1;
                            end
                            js = slot_inc(js);
                        end
                        maxl_next = FRAME_W'(delay_reg);
                    end
                    OP_LOCAL: begin
                        pfr_next = sum_reg[FRAME_W-1:0];
                        if (FRAME_W'(delay_reg) >= FRAME_W'(DEPTH) || sum_reg[FRAME_W]) begin
                            pst_next = STS_REJECT;
                        end else begin
                            lf_next[ins_slot]  = 1'b1;
                            lwv_next[ins_slot] = 1'b1;
                            st_ctl.l_we        = 1'b1;
                            if (sum_reg[FRAME_W-1:0] > maxl_reg) begin
                                maxl_next = sum_reg[FRAME_W-1:0];
                            end
                        end
                    end
                    OP_REMOTE: begin
                        pfr_next = frame_reg;
                        if (batch_reg && (diff_reg[FRAME_W] || !f_le_hi_reg)) begin
                            pst_next = STS_SKIP;
                        end else if (diff_reg[FRAME_W]
                                     || diff_reg[FRAME_W-1:0] >= FRAME_W'(DEPTH)) begin
                            pst_next = STS_REJECT;
                        end else begin
                            rf_next[ins_slot] = 1'b1;
                            st_ctl.r_we       = 1'b1;
                            if (frame_reg > maxr_reg) begin
                                maxr_next = frame_reg;
                            end
                        end
                    end
                    OP_ADVANCE: begin
                        if (adv_ok) begin
                            st_ctl.rd_en     = 1'b1;
                            st_raddr         = cs_reg;
                            rlv_next         = lwv_reg[cs_reg];
                            lf_next[cs_reg]  = 1'b0;
                            rf_next[cs_reg]  = 1'b0;
                            lwv_next[cs_reg] = 1'b0;
                            cur_next         = cur_reg + 1'b1;
                            cs_next          = (&cur_reg) ? '0 : slot_inc(cs_reg);
                            phas_next        = 1'b1;
                            prw_next         = 1'b1;
                        end else begin
                            pst_next = STS_REJECT;
                        end
                    end
                    OP_WALK: begin
                        if (lf_reg[cs_reg]) begin
                            wf_next  = cur_reg;
                            ws_next  = cs_reg;
                            cnt_next = '0;
                        end else begin
                            pst_next = STS_REJECT;
                        end
                    end
                    OP_QUERY: begin
                        pst_next = STS_DONE;
                    end
                    default: begin
                        pst_next = STS_REJECT;
                    end
                endcase
            end
            ST_HI: begin
                hi_next = (maxr_reg > maxl_reg) ? maxr_reg : maxl_reg;
            end
            ST_READ: begin
                st_ctl.rd_en = 1'b1;
                st_raddr     = ws_reg;
                rlv_next     = lwv_reg[ws_reg];
                pst_next     = STS_DONE;
                pfr_next     = wf_reg;
                phas_next    = 1'b1;
                prw_next     = 1'b0;
                plast_next   = !walk_more;
                wf_next      = wf_reg + 1'b1;
                ws_next      = slot_inc(ws_reg);
                cnt_next     = cnt_reg + 1'b1;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(prw_reg ? PAYLOAD_W'(r_rdata) : '0),
                                    ((phas_reg && rlv_reg) ? PAYLOAD_W'(l_rdata) : '0),
                                    pfr_reg};
                    m_user_next  = {rdy, phas_reg, pst_reg};
                    m_last_next  = plast_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            delay_reg   <= '0;
            cur_reg     <= '0;
            cs_reg      <= '0;
            maxr_reg    <= '0;
            maxl_reg    <= '0;
            hi_reg      <= '0;
            lf_reg      <= '0;
            rf_reg      <= '0;
            lwv_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            delay_reg   <= delay_next;
            cur_reg     <= cur_next;
            cs_reg      <= cs_next;
            maxr_reg    <= maxr_next;
            maxl_reg    <= maxl_next;
            hi_reg      <= hi_next;
            lf_reg      <= lf_next;
            rf_reg      <= rf_next;
            lwv_reg     <= lwv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        frame_reg     <= frame_next;
        payload_reg   <= payload_next;
        batch_reg     <= batch_next;
        diff_reg      <= diff_next;
        sum_reg       <= sum_next;
        f_le_hi_reg   <= f_le_hi_next;
        cur_le_hi_reg <= cur_le_hi_next;
        pst_reg       <= pst_next;
        pfr_reg       <= pfr_next;
        phas_reg      <= phas_next;
        prw_reg       <= prw_next;
        plast_reg     <= plast_next;
        wf_reg        <= wf_next;
        ws_reg        <= ws_next;
        cnt_reg       <= cnt_next;
        rlv_reg       <= rlv_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
        m_last_reg    <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ----- design/fijb_checker.sv -----
// Port-level checks of the frame input jitter buffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fijb_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [fijb_pkg::OUT_USER_W-1:0]     m_axis_tuser,
    input wire logic                                m_axis_tlast
);
    import fijb_pkg::*;

    logic [STATUS_W-1:0] sts;
    assign sts = m_axis_tuser[STATUS_W-1:0];

    `FIJB_ASSERT(a_m_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "m word dropped")
    `FIJB_ASSERT_IMP(a_sts_ok, aclk, aresetn, m_axis_tvalid, sts == STS_DONE || sts == STS_REJECT || sts == STS_SKIP, "bad status")
    `FIJB_ASSERT_IMP(a_data_done, aclk, aresetn, m_axis_tvalid && m_axis_tuser[STATUS_W], sts == STS_DONE, "data on failed status")
    `FIJB_ASSERT_IMP(a_fail_last, aclk, aresetn, m_axis_tvalid && sts != STS_DONE, m_axis_tlast, "failed result not last")
    `FIJB_ASSERT(a_one_word, aclk, aresetn, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "back to back accept")

endmodule

bind frame_input_jitter_buffer fijb_checker u_fijb_checker (.*);

`default_nettype wire
